// ===== rtl/csvtok_pkg.sv =====
// shared types and constants for the csv byte tokenizer
package csvtok_pkg;

  localparam int MAX_FIELDS = 64;
  localparam int BYTE_W     = 8;
  localparam int FIELD_W    = 7;

  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_QUOTE  = 2'd1,
    CLS_BSLASH = 2'd2,
    CLS_OTHER  = 2'd3
  } cls_t;

  typedef struct packed {
    logic               quoted;
    cls_t               prev_class;
    logic               skip_next;
    logic [FIELD_W-1:0] field_number;
  } state_t;

  typedef struct packed {
    logic               byte_valid;
    logic [BYTE_W-1:0]  out_byte;
    logic               field_done;
    logic [FIELD_W-1:0] field_slot;
    logic               slot_exists;
    logic               line_done;
    logic               byte_skipped;
  } result_t;

endpackage

// ===== rtl/csvtok_if.sv =====
// channel interfaces for bytes in, tokens out and the field count register
interface csvtok_in_if;
  logic                            valid;
  logic                            ready;
  logic [csvtok_pkg::BYTE_W-1:0]   in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface csvtok_out_if;
  logic                            valid;
  logic                            ready;
  logic                            byte_valid;
  logic [csvtok_pkg::BYTE_W-1:0]   out_byte;
  logic                            field_done;
  logic [csvtok_pkg::FIELD_W-1:0]  field_slot;
  logic                            slot_exists;
  logic                            line_done;
  logic                            byte_skipped;
  modport source (output valid, output byte_valid, output out_byte, output field_done,
                  output field_slot, output slot_exists, output line_done,
                  output byte_skipped, input ready);
  modport sink (input valid, input byte_valid, input out_byte, input field_done,
                input field_slot, input slot_exists, input line_done,
                input byte_skipped, output ready);
endinterface

interface csvtok_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [csvtok_pkg::FIELD_W-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/csvtok_step.sv =====
// per-byte tokenizer decision logic and next state
module csvtok_step (
  input  csvtok_pkg::state_t                st,
  input  logic [csvtok_pkg::BYTE_W-1:0]     in_byte,
  input  logic [csvtok_pkg::FIELD_W-1:0]    field_count,
  output csvtok_pkg::result_t               res,
  output csvtok_pkg::state_t                st_next
);

  logic [csvtok_pkg::FIELD_W-1:0] limit;
  logic                           escaped;

  // effective column count
  assign limit = (field_count < csvtok_pkg::FIELD_W'(csvtok_pkg::MAX_FIELDS)) ?
                 field_count : csvtok_pkg::FIELD_W'(csvtok_pkg::MAX_FIELDS);

  always_comb begin
    res     = '0;
    st_next = st;
    escaped = 1'b0;
    if (st.skip_next) begin
      st_next.skip_next = 1'b0;
      res.byte_skipped  = 1'b1;
    end else begin
      case (in_byte)
        csvtok_pkg::CH_QUOTE: begin
          if (st.prev_class == csvtok_pkg::CLS_QUOTE ||
              st.prev_class == csvtok_pkg::CLS_BSLASH) begin
            res.byte_valid = 1'b1;
            res.out_byte   = in_byte;
            escaped        = 1'b1;
            if (st.prev_class == csvtok_pkg::CLS_QUOTE) begin
              st_next.quoted = 1'b1;
            end
          end else begin
            st_next.quoted = ~st.quoted;
          end
        end
        csvtok_pkg::CH_BSLASH: begin
          if (st.prev_class == csvtok_pkg::CLS_BSLASH) begin
            res.byte_valid = 1'b1;
            res.out_byte   = in_byte;
            escaped        = 1'b1;
          end
        end
        csvtok_pkg::CH_CR, csvtok_pkg::CH_LF: begin
          if (st.quoted) begin
            res.byte_valid = 1'b1;
            res.out_byte   = in_byte;
          end else begin
            res.line_done  = 1'b1;
            res.field_done = 1'b1;
          end
        end
        csvtok_pkg::CH_COMMA: begin
          if (st.quoted) begin
            res.byte_valid = 1'b1;
            res.out_byte   = in_byte;
          end else begin
            res.field_done = 1'b1;
          end
        end
        default: begin
          res.byte_valid = 1'b1;
          res.out_byte   = in_byte;
        end
      endcase

      if (res.field_done) begin
        res.field_slot = st.field_number;
        if (st.field_number < limit) begin
          res.slot_exists      = 1'b1;
          st_next.field_number = st.field_number + csvtok_pkg::FIELD_W'(1);
        end
      end

      if (escaped) begin
        st_next.prev_class = csvtok_pkg::CLS_NONE;
      end else if (in_byte == csvtok_pkg::CH_QUOTE) begin
        st_next.prev_class = csvtok_pkg::CLS_QUOTE;
      end else if (in_byte == csvtok_pkg::CH_BSLASH) begin
        st_next.prev_class = csvtok_pkg::CLS_BSLASH;
      end else begin
        st_next.prev_class = csvtok_pkg::CLS_OTHER;
      end

      // end of record
      if (res.line_done) begin
        st_next.skip_next    = (in_byte == csvtok_pkg::CH_CR);
        st_next.quoted       = 1'b0;
        st_next.prev_class   = csvtok_pkg::CLS_NONE;
        st_next.field_number = '0;
      end
    end
  end

endmodule

// ===== rtl/csvtok_out_reg.sv =====
// result register driving the token output channel
module csvtok_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  csvtok_pkg::result_t  res,
  output logic                 free,
  csvtok_out_if.source         tokens
);

  logic                valid;
  csvtok_pkg::result_t held;

  assign free = !valid || tokens.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (tokens.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign tokens.valid        = valid;
  assign tokens.byte_valid   = held.byte_valid;
  assign tokens.out_byte     = held.out_byte;
  assign tokens.field_done   = held.field_done;
  assign tokens.field_slot   = held.field_slot;
  assign tokens.slot_exists  = held.slot_exists;
  assign tokens.line_done    = held.line_done;
  assign tokens.byte_skipped = held.byte_skipped;

endmodule

// ===== rtl/csv_byte_tokenizer_top.sv =====
// top level of the csv byte tokenizer: input register, state, result register
// an accepted byte is held in the input register, then in the result register, which drives tokens
// throughput: one byte per cycle while tokens.ready is high, set by the state update loop
// the input register accepts a new byte while the result register holds one
// reset (synchronous, active high) clears both stages, the field count and the parse state
// the field count register takes writes every cycle
module csv_byte_tokenizer_top (
  input  logic          clk,
  input  logic          rst,
  csvtok_in_if.sink     bytes,
  csvtok_out_if.source  tokens,
  csvtok_cfg_if.sink    cfg
);

  logic                            s1_valid;
  logic [csvtok_pkg::BYTE_W-1:0]   s1_byte;
  logic [csvtok_pkg::FIELD_W-1:0]  field_count;
  csvtok_pkg::state_t              st;
  csvtok_pkg::state_t              st_next;
  csvtok_pkg::result_t             res;
  logic                            out_free;
  logic                            advance;

  assign advance     = s1_valid && out_free;
  assign bytes.ready = !s1_valid || advance;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_count <= '0;
    end else if (cfg.valid) begin
      field_count <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      s1_byte <= bytes.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.quoted       <= 1'b0;
      st.prev_class   <= csvtok_pkg::CLS_NONE;
      st.skip_next    <= 1'b0;
      st.field_number <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  csvtok_step u_step (
    .st          (st),
    .in_byte     (s1_byte),
    .field_count (field_count),
    .res         (res),
    .st_next     (st_next)
  );

  csvtok_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (advance),
    .res    (res),
    .free   (out_free),
    .tokens (tokens)
  );

`ifndef ASSERT_OFF
  // a line end always closes a field
  assert property (@(posedge clk) disable iff (rst)
    tokens.valid && tokens.line_done |-> tokens.field_done)
    else $error("line end without field end");

  // a skipped byte reports nothing else
  assert property (@(posedge clk) disable iff (rst)
    tokens.valid && tokens.byte_skipped |->
      !tokens.byte_valid && !tokens.field_done && !tokens.line_done)
    else $error("skipped byte carries data");

  // field counter restarts after a line end
  assert property (@(posedge clk) disable iff (rst)
    advance && res.line_done |=> st.field_number == '0 && !st.quoted)
    else $error("state not cleared at line end");

  // field counter never passes MAX_FIELDS
  assert property (@(posedge clk) disable iff (rst)
    st.field_number <= csvtok_pkg::FIELD_W'(csvtok_pkg::MAX_FIELDS))
    else $error("field number out of range");

  // no byte is dropped between the stages
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_byte))
    else $error("input stage lost a byte");
`endif

endmodule

// ===== tb/csvtok_token_checker.sv =====
// checker that predicts each token of the csv byte tokenizer and compares it
module csvtok_token_checker (
  input  logic  clk,
  input  logic  rst,
  csvtok_in_if  bytes,
  csvtok_out_if tokens,
  csvtok_cfg_if cfg,
  output int    pending,
  output int    fails
);

  logic                           in_quotes;
  csvtok_pkg::cls_t               last_class;
  logic                           drop_next;
  logic [csvtok_pkg::FIELD_W-1:0] field_idx;
  logic [csvtok_pkg::FIELD_W-1:0] column_count;
  csvtok_pkg::result_t            expected_tokens[$];
  csvtok_pkg::result_t            want;
  int                             mismatches = 0;

  function automatic csvtok_pkg::result_t next_token(input logic [csvtok_pkg::BYTE_W-1:0] c);
    csvtok_pkg::result_t            r;
    logic                           escaped;
    logic [csvtok_pkg::FIELD_W-1:0] limit;
    r = '0;
    escaped = 1'b0;
    if (drop_next) begin
      drop_next = 1'b0;
      r.byte_skipped = 1'b1;
    end else begin
      case (c)
        csvtok_pkg::CH_QUOTE: begin
          if (last_class == csvtok_pkg::CLS_QUOTE || last_class == csvtok_pkg::CLS_BSLASH) begin
            r.byte_valid = 1'b1;
            r.out_byte = c;
            escaped = 1'b1;
            if (last_class == csvtok_pkg::CLS_QUOTE) in_quotes = 1'b1;
          end else begin
            in_quotes = ~in_quotes;
          end
        end
        csvtok_pkg::CH_BSLASH: begin
          if (last_class == csvtok_pkg::CLS_BSLASH) begin
            r.byte_valid = 1'b1;
            r.out_byte = c;
            escaped = 1'b1;
          end
        end
        csvtok_pkg::CH_CR, csvtok_pkg::CH_LF: begin
          if (in_quotes) begin
            r.byte_valid = 1'b1;
            r.out_byte = c;
          end else begin
            r.line_done = 1'b1;
            r.field_done = 1'b1;
          end
        end
        csvtok_pkg::CH_COMMA: begin
          if (in_quotes) begin
            r.byte_valid = 1'b1;
            r.out_byte = c;
          end else begin
            r.field_done = 1'b1;
          end
        end
        default: begin
          r.byte_valid = 1'b1;
          r.out_byte = c;
        end
      endcase
      if (r.field_done) begin
        limit = (column_count < csvtok_pkg::MAX_FIELDS) ? column_count :
                csvtok_pkg::FIELD_W'(csvtok_pkg::MAX_FIELDS);
        r.field_slot = field_idx;
        if (field_idx < limit) begin
          r.slot_exists = 1'b1;
          field_idx = field_idx + csvtok_pkg::FIELD_W'(1);
        end
      end
      if (escaped) last_class = csvtok_pkg::CLS_NONE;
      else if (c == csvtok_pkg::CH_QUOTE) last_class = csvtok_pkg::CLS_QUOTE;
      else if (c == csvtok_pkg::CH_BSLASH) last_class = csvtok_pkg::CLS_BSLASH;
      else last_class = csvtok_pkg::CLS_OTHER;
      if (r.line_done) begin
        drop_next = (c == csvtok_pkg::CH_CR);
        in_quotes = 1'b0;
        last_class = csvtok_pkg::CLS_NONE;
        field_idx = '0;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0d got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_quotes = 1'b0;
      last_class = csvtok_pkg::CLS_NONE;
      drop_next = 1'b0;
      field_idx = '0;
      column_count = '0;
      expected_tokens.delete();
    end else begin
      if (cfg.valid && cfg.ready) column_count = cfg.data;
      if (bytes.valid && bytes.ready) expected_tokens.push_back(next_token(bytes.in_byte));
      if (tokens.valid && tokens.ready) begin
        if (expected_tokens.size() == 0) begin
          $error("token item with no byte waiting");
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("byte_valid", want.byte_valid, tokens.byte_valid);
          check_field("out_byte", want.out_byte, tokens.out_byte);
          check_field("field_done", want.field_done, tokens.field_done);
          check_field("field_slot", want.field_slot, tokens.field_slot);
          check_field("slot_exists", want.slot_exists, tokens.slot_exists);
          check_field("line_done", want.line_done, tokens.line_done);
          check_field("byte_skipped", want.byte_skipped, tokens.byte_skipped);
        end
      end
    end
    pending <= expected_tokens.size();
    fails <= mismatches;
  end

endmodule

// ===== tb/csv_byte_tokenizer_top_test.sv =====
// stimulus and verdict for the csv byte tokenizer, checked by csvtok_token_checker
module csv_byte_tokenizer_top_test;

  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 300;
  localparam int CALM_FROM   = 1500;
  localparam int CALM_TO     = 2100;

  logic                          clk;
  logic                          rst;
  int                            cycle = 0;
  int                            quiet_cycles = 0;
  int                            pending;
  int                            fails;
  int                            sent = 0;
  logic [csvtok_pkg::BYTE_W-1:0] line_bytes[$];

  csvtok_in_if  bytes_ch ();
  csvtok_out_if tokens_ch ();
  csvtok_cfg_if cfg_ch ();

  csv_byte_tokenizer_top DUT (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_ch),
    .tokens (tokens_ch),
    .cfg    (cfg_ch)
  );

  csvtok_token_checker scoreboard (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes_ch),
    .tokens  (tokens_ch),
    .cfg     (cfg_ch),
    .pending (pending),
    .fails   (fails)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic calm();
    return cycle >= CALM_FROM && cycle < CALM_TO;
  endfunction

  function automatic logic [csvtok_pkg::BYTE_W-1:0] letter();
    return 8'h61 + csvtok_pkg::BYTE_W'($urandom_range(0, 25));
  endfunction

  always @(posedge clk) begin
    cycle <= cycle + 1;
    tokens_ch.ready <= calm() || ($urandom_range(0, 99) >= 33);
    if ((bytes_ch.valid && bytes_ch.ready) || (tokens_ch.valid && tokens_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("csv_byte_tokenizer_top_test: errors");
      $finish;
    end
  end

  task automatic send_byte(input logic [csvtok_pkg::BYTE_W-1:0] b);
    if (!calm() && $urandom_range(0, 99) < 33) begin
      bytes_ch.valid <= 1'b0;
      do @(posedge clk); while (!calm() && $urandom_range(0, 99) < 33);
    end
    bytes_ch.valid <= 1'b1;
    bytes_ch.in_byte <= b;
    do @(posedge clk); while (!bytes_ch.ready);
    sent++;
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_byte(line_bytes[i]);
    line_bytes.delete();
  endtask

  task automatic wait_idle();
    bytes_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_field_count(input logic [csvtok_pkg::FIELD_W-1:0] v);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly well-formed records, some noise and broken escapes
  task automatic build_record(input int fields, input bit plain_only);
    int kind;
    for (int f = 0; f < fields; f++) begin
      if (f > 0) line_bytes.push_back(csvtok_pkg::CH_COMMA);
      kind = plain_only ? 0 : $urandom_range(0, 9);
      if (kind < 5) begin
        repeat ($urandom_range(0, 3)) line_bytes.push_back(letter());
      end else if (kind < 8) begin
        line_bytes.push_back(csvtok_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(0, 6))
            0: line_bytes.push_back(letter());
            1: line_bytes.push_back(csvtok_pkg::CH_COMMA);
            2: line_bytes.push_back(csvtok_pkg::CH_CR);
            3: line_bytes.push_back(csvtok_pkg::CH_LF);
            4: begin
              line_bytes.push_back(csvtok_pkg::CH_QUOTE);
              line_bytes.push_back(csvtok_pkg::CH_QUOTE);
            end
            5: begin
              line_bytes.push_back(csvtok_pkg::CH_BSLASH);
              line_bytes.push_back(csvtok_pkg::CH_QUOTE);
            end
            default: begin
              line_bytes.push_back(csvtok_pkg::CH_BSLASH);
              line_bytes.push_back(csvtok_pkg::CH_BSLASH);
            end
          endcase
        end
        line_bytes.push_back(csvtok_pkg::CH_QUOTE);
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 3))
          line_bytes.push_back(csvtok_pkg::BYTE_W'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 4))
          0: line_bytes.push_back(csvtok_pkg::CH_QUOTE);
          1: line_bytes.push_back(csvtok_pkg::CH_BSLASH);
          2: line_bytes.push_back(csvtok_pkg::CH_CR);
          3: line_bytes.push_back(csvtok_pkg::CH_LF);
          default: line_bytes.push_back(csvtok_pkg::CH_COMMA);
        endcase
      end
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        line_bytes.push_back(csvtok_pkg::CH_CR);
        line_bytes.push_back(csvtok_pkg::CH_LF);
      end
      6, 7: line_bytes.push_back(csvtok_pkg::CH_LF);
      8: begin
        line_bytes.push_back(csvtok_pkg::CH_CR);
        line_bytes.push_back(csvtok_pkg::BYTE_W'($urandom_range(0, 255)));
      end
      default: ;
    endcase
  endtask

  initial begin
    logic [csvtok_pkg::FIELD_W-1:0] counts[5];
    int                             phase_start;
    rst = 1'b1;
    bytes_ch.valid = 1'b0;
    bytes_ch.in_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // quotes, escapes, cr skipping a non-lf byte, byte extremes, extra fields
    write_field_count(3);
    line_bytes = '{8'h61, csvtok_pkg::CH_COMMA, csvtok_pkg::CH_QUOTE, csvtok_pkg::CH_COMMA,
                   csvtok_pkg::CH_QUOTE, csvtok_pkg::CH_QUOTE, csvtok_pkg::CH_COMMA,
                   csvtok_pkg::CH_BSLASH, csvtok_pkg::CH_QUOTE, csvtok_pkg::CH_BSLASH,
                   csvtok_pkg::CH_BSLASH, csvtok_pkg::CH_BSLASH, 8'h71, csvtok_pkg::CH_QUOTE,
                   csvtok_pkg::CH_CR, 8'h5A, 8'h00, 8'hFF, csvtok_pkg::CH_COMMA,
                   csvtok_pkg::CH_COMMA, csvtok_pkg::CH_COMMA, csvtok_pkg::CH_COMMA,
                   csvtok_pkg::CH_LF, csvtok_pkg::CH_QUOTE, csvtok_pkg::CH_CR,
                   csvtok_pkg::CH_LF, csvtok_pkg::CH_QUOTE, csvtok_pkg::CH_CR,
                   csvtok_pkg::CH_LF};
    send_line();

    counts = '{7'd0, 7'd64, 7'd127, 7'd1, csvtok_pkg::FIELD_W'($urandom_range(2, 63))};
    foreach (counts[p]) begin
      write_field_count(counts[p]);
      phase_start = sent;
      build_record($urandom_range(65, 70), 1'b1);
      send_line();
      while (sent - phase_start < PHASE_ITEMS) begin
        build_record(($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6),
                     1'b0);
        send_line();
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (fails == 0) begin
      $display("csv_byte_tokenizer_top_test: clean");
    end else begin
      $display("csv_byte_tokenizer_top_test: errors");
    end
    $finish;
  end

endmodule
